### src/csvt_pkg.sv
// -----------------------------------------------------------------------------
// csvt_pkg
// Types, codes and constants shared by the strict CSV tokenizer modules.
// -----------------------------------------------------------------------------
package csvt_pkg;

   // Width of the internal fields-completed counter; it saturates at its maximum.
   localparam int unsigned COUNT_WIDTH = 8;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] NUL_CHAR   = 8'h00;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] CR_CHAR    = 8'h0D;
   localparam logic [7:0] DELIM_RESET = 8'd44;

   typedef enum logic [2:0] {
      ST_START  = 3'd0,
      ST_PLAIN  = 3'd1,
      ST_QUOTED = 3'd2,
      ST_QSEEN  = 3'd3,
      ST_SKIP   = 3'd4
   } parse_state_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_QUOTE_PLAIN  = 2'd1,
      STATUS_GARBAGE      = 2'd2,
      STATUS_UNTERMINATED = 2'd3
   } status_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       field_end;
      logic       line_end;
      logic [7:0] field_count;
      logic [1:0] status;
   } result_type;

   // Count as reported on the result channel, clamped to eight bits.
   function automatic logic [7:0] clamp_count(input logic [COUNT_WIDTH-1:0] count);
      logic [COUNT_WIDTH+7:0] wide;
      begin
         wide = {8'd0, count};
         if (wide > (COUNT_WIDTH+8)'(255)) begin
            clamp_count = 8'hFF;
         end else begin
            clamp_count = wide[7:0];
         end
      end
   endfunction

endpackage

### src/csvt_if.sv
// -----------------------------------------------------------------------------
// csvt_if
// Valid/ready channel interfaces for the byte input and the token output.
// -----------------------------------------------------------------------------
interface csvt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

interface csvt_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] out_byte;
   logic       field_end;
   logic       line_end;
   logic [7:0] field_count;
   logic [1:0] status;

   modport source (output valid, output byte_valid, output out_byte, output field_end,
                   output line_end, output field_count, output status, input ready);
   modport sink (input valid, input byte_valid, input out_byte, input field_end,
                 input line_end, input field_count, input status, output ready);
endinterface

### src/strict_csv_tokenizer_top.sv
// -----------------------------------------------------------------------------
// strict_csv_tokenizer_top
// Strict CSV tokenizer: one text byte in, at most one token out per byte.
//
//   Channel  Direction  Carries
//   req_ch   in         char_in, one text byte per transaction
//   rsp_ch   out        byte_valid, out_byte, field_end, line_end,
//                       field_count, status
//   csr_*    in         delimiter byte, written when csr_wr_en is high
//
// A byte is taken into the input register, parsed from there and its token,
// if any, lands in the result register. One byte per cycle is sustained while
// no waiting token stalls the result channel.
// Synchronous reset clears the state machine, the field count, both valid
// flags and sets the delimiter to a comma. A stalled result channel holds the
// parser only when a token is waiting and another one is due.
// -----------------------------------------------------------------------------
module strict_csv_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   csvt_req_if.sink    req_ch,
   csvt_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import csvt_pkg::*;

   logic [7:0] delimiter_ff;
   logic       held_valid;
   logic [7:0] held_char;
   logic       has_result;
   result_type result;
   logic       can_load;
   logic       step;

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DELIM_RESET;
      end else if (csr_wr_en) begin
         delimiter_ff <= csr_wr_data;
      end
   end

   // Bytes without a token move on even while the result register is full.
   assign step = held_valid && (can_load || !has_result);

   csvt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_char    (req_ch.char_in),
      .in_ready   (req_ch.ready),
      .consume    (step),
      .held_valid (held_valid),
      .held_char  (held_char)
   );

   csvt_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .char_in    (held_char),
      .delimiter  (delimiter_ff),
      .has_result (has_result),
      .result     (result)
   );

   csvt_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (step && has_result),
      .result   (result),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );
endmodule

### src/csvt_in_stage.sv
// -----------------------------------------------------------------------------
// csvt_in_stage
// Input register holding one accepted byte until the parser consumes it.
// -----------------------------------------------------------------------------
module csvt_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_char,
   output logic       in_ready,
   input  logic       consume,
   output logic       held_valid,
   output logic [7:0] held_char
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] char_ff;

   // The register can take a new byte when empty or when its byte leaves now.
   assign in_ready   = !valid_ff || consume;
   assign held_valid = valid_ff;
   assign held_char  = char_ff;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         char_ff <= in_char;
      end
   end
endmodule

### src/csvt_parser.sv
// -----------------------------------------------------------------------------
// csvt_parser
// Field state machine and field counter; turns one byte into at most one token.
// -----------------------------------------------------------------------------
module csvt_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          char_in,
   input  logic [7:0]          delimiter,
   output logic                has_result,
   output csvt_pkg::result_type result
);
   import csvt_pkg::*;

   parse_state_type         state_ff;
   parse_state_type         state_in;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [COUNT_WIDTH-1:0]  count_in;
   logic [COUNT_WIDTH-1:0]  count_inc;
   logic                    is_eol;
   logic                    is_delim;
   logic                    is_quote;

   assign is_eol   = (char_in == NUL_CHAR) || (char_in == LF_CHAR) || (char_in == CR_CHAR);
   assign is_delim = (char_in == delimiter);
   assign is_quote = (char_in == QUOTE_CHAR);
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // Next state and counter.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_PLAIN: begin
            if (is_eol || is_delim) begin
               state_in = ST_START;
               count_in = is_eol ? '0 : count_inc;
            end else if (is_quote) begin
               state_in = ST_SKIP;
               count_in = '0;
            end
         end
         ST_QUOTED: begin
            if (is_eol) begin
               state_in = ST_START;
               count_in = '0;
            end else if (is_quote) begin
               state_in = ST_QSEEN;
            end
         end
         ST_QSEEN: begin
            if (is_eol || (is_delim && !is_quote)) begin
               state_in = ST_START;
               count_in = is_eol ? '0 : count_inc;
            end else if (is_quote) begin
               state_in = ST_QUOTED;
            end else begin
               state_in = ST_SKIP;
               count_in = '0;
            end
         end
         ST_SKIP: begin
            if (is_eol) begin
               state_in = ST_START;
            end
         end
         default: begin
            // Field start; unused codes behave the same way.
            if (is_eol || is_delim) begin
               state_in = ST_START;
               count_in = is_eol ? '0 : count_inc;
            end else if (is_quote) begin
               state_in = ST_QUOTED;
            end else begin
               state_in = ST_PLAIN;
            end
         end
      endcase
   end

   // Token for this byte.
   always_comb begin
      has_result         = 1'b0;
      result.byte_valid  = 1'b0;
      result.out_byte    = 8'd0;
      result.field_end   = 1'b0;
      result.line_end    = 1'b0;
      result.field_count = clamp_count(count_ff);
      result.status      = STATUS_OK;
      case (state_ff)
         ST_PLAIN: begin
            has_result = 1'b1;
            if (is_eol || is_delim) begin
               result.field_end   = 1'b1;
               result.line_end    = is_eol;
               result.field_count = clamp_count(count_inc);
            end else if (is_quote) begin
               result.line_end = 1'b1;
               result.status   = STATUS_QUOTE_PLAIN;
            end else begin
               result.byte_valid = 1'b1;
               result.out_byte   = char_in;
            end
         end
         ST_QUOTED: begin
            if (is_eol) begin
               has_result      = 1'b1;
               result.line_end = 1'b1;
               result.status   = STATUS_UNTERMINATED;
            end else if (!is_quote) begin
               has_result        = 1'b1;
               result.byte_valid = 1'b1;
               result.out_byte   = char_in;
            end
         end
         ST_QSEEN: begin
            has_result = 1'b1;
            if (is_eol || (is_delim && !is_quote)) begin
               result.field_end   = 1'b1;
               result.line_end    = is_eol;
               result.field_count = clamp_count(count_inc);
            end else if (is_quote) begin
               // A doubled quote stands for one literal quote.
               result.byte_valid = 1'b1;
               result.out_byte   = QUOTE_CHAR;
            end else begin
               result.line_end = 1'b1;
               result.status   = STATUS_GARBAGE;
            end
         end
         ST_SKIP: begin
            has_result = 1'b0;
         end
         default: begin
            if (is_eol || is_delim) begin
               has_result         = 1'b1;
               result.field_end   = 1'b1;
               result.line_end    = is_eol;
               result.field_count = clamp_count(count_inc);
            end else if (!is_quote) begin
               has_result        = 1'b1;
               result.byte_valid = 1'b1;
               result.out_byte   = char_in;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         count_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end
endmodule

### src/csvt_out_stage.sv
// -----------------------------------------------------------------------------
// csvt_out_stage
// Result register driving the token channel.
// -----------------------------------------------------------------------------
module csvt_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  csvt_pkg::result_type result,
   output logic                 can_load,
   csvt_rsp_if.source           rsp_ch
);
   import csvt_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // A new token may enter when the register is empty or its token leaves now.
   assign can_load = !valid_ff || rsp_ch.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.byte_valid  = result_ff.byte_valid;
   assign rsp_ch.out_byte    = result_ff.out_byte;
   assign rsp_ch.field_end   = result_ff.field_end;
   assign rsp_ch.line_end    = result_ff.line_end;
   assign rsp_ch.field_count = result_ff.field_count;
   assign rsp_ch.status      = result_ff.status;
endmodule

### verif/csv_token_checker.sv
// -----------------------------------------------------------------------------
// csv_token_checker
// Watches the byte and token channels of the strict CSV tokenizer. It tracks
// the field state machine and the delimiter register, predicts the token of
// every accepted byte that yields one and compares each token with the oldest prediction.
// -----------------------------------------------------------------------------
module csv_token_checker (
   input  logic        clock,
   input  logic        reset,
   csvt_req_if         req_ch,
   csvt_rsp_if         rsp_ch,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_count
);
   import csvt_pkg::*;

   parse_state_type        scan_state;
   logic [COUNT_WIDTH-1:0] fields_closed;
   logic [7:0]             delim_char;
   result_type             expected_tokens[$];
   int                     mismatches = 0;

   // The token channel shows at most eight bits of the field count.
   function automatic logic [7:0] shown_count();
      int unsigned wide;
      wide = fields_closed;
      return (wide > 255) ? 8'hFF : wide[7:0];
   endfunction

   function automatic result_type make_token(input logic bv, input logic [7:0] b,
                                             input logic fe, input logic le,
                                             input status_type st);
      result_type tok;
      tok.byte_valid = bv;
      tok.out_byte = b;
      tok.field_end = fe;
      tok.line_end = le;
      tok.field_count = shown_count();
      tok.status = st;
      return tok;
   endfunction

   function automatic result_type close_field(input bit eol);
      result_type tok;
      if (fields_closed != COUNT_MAX) fields_closed = fields_closed + 1'b1;
      tok = make_token(1'b0, 8'h00, 1'b1, eol, STATUS_OK);
      if (eol) fields_closed = '0;
      scan_state = ST_START;
      return tok;
   endfunction

   // An error closes the line at once; unless the byte was a line end, the
   // rest of the line is skipped.
   function automatic result_type abort_line(input status_type code, input bit eol);
      result_type tok;
      tok = make_token(1'b0, 8'h00, 1'b0, 1'b1, code);
      fields_closed = '0;
      scan_state = eol ? ST_START : ST_SKIP;
      return tok;
   endfunction

   // Advances the field state by one byte; returns 1 when a token is due.
   function automatic bit tokenize(input logic [7:0] c, output result_type tok);
      bit eol;
      bit delim;
      bit quote;
      eol = (c == NUL_CHAR) || (c == LF_CHAR) || (c == CR_CHAR);
      delim = (c == delim_char);
      quote = (c == QUOTE_CHAR);
      tok = '0;
      case (scan_state)
         ST_PLAIN: begin
            if (eol || delim) tok = close_field(eol);
            else if (quote) tok = abort_line(STATUS_QUOTE_PLAIN, 1'b0);
            else tok = make_token(1'b1, c, 1'b0, 1'b0, STATUS_OK);
            return 1'b1;
         end
         ST_QUOTED: begin
            if (eol) begin
               tok = abort_line(STATUS_UNTERMINATED, 1'b1);
            end else if (quote) begin
               scan_state = ST_QSEEN;
               return 1'b0;
            end else begin
               tok = make_token(1'b1, c, 1'b0, 1'b0, STATUS_OK);
            end
            return 1'b1;
         end
         ST_QSEEN: begin
            if (eol || (delim && !quote)) begin
               tok = close_field(eol);
            end else if (quote) begin
               scan_state = ST_QUOTED;
               tok = make_token(1'b1, QUOTE_CHAR, 1'b0, 1'b0, STATUS_OK);
            end else begin
               tok = abort_line(STATUS_GARBAGE, 1'b0);
            end
            return 1'b1;
         end
         ST_SKIP: begin
            if (eol) scan_state = ST_START;
            return 1'b0;
         end
         default: begin
            if (eol || delim) begin
               tok = close_field(eol);
            end else if (quote) begin
               scan_state = ST_QUOTED;
               return 1'b0;
            end else begin
               scan_state = ST_PLAIN;
               tok = make_token(1'b1, c, 1'b0, 1'b0, STATUS_OK);
            end
            return 1'b1;
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         scan_state = ST_START;
         fields_closed = '0;
         delim_char = DELIM_RESET;
         expected_tokens.delete();
      end else begin
         if (csr_wr_en) delim_char = csr_wr_data;
         if (req_ch.valid && req_ch.ready) begin
            if (tokenize(req_ch.char_in, want)) expected_tokens.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.byte_valid = rsp_ch.byte_valid;
            got.out_byte = rsp_ch.out_byte;
            got.field_end = rsp_ch.field_end;
            got.line_end = rsp_ch.line_end;
            got.field_count = rsp_ch.field_count;
            got.status = rsp_ch.status;
            if (expected_tokens.size() == 0) begin
               $error("token with none expected: byte_valid %0d out_byte %0d status %0d",
                      got.byte_valid, got.out_byte, got.status);
               mismatches++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("byte_valid", want.byte_valid, got.byte_valid);
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("field_end", want.field_end, got.field_end);
               check_field("line_end", want.line_end, got.line_end);
               check_field("field_count", want.field_count, got.field_count);
               check_field("status", want.status, got.status);
            end
         end
      end
      fail_count <= mismatches;
      pending_count <= expected_tokens.size();
   end

endmodule

### verif/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Testbench for the strict CSV tokenizer. Feeds a short directed sequence and
// then random CSV lines, mostly well formed with some broken ones and noise,
// under several delimiters and handshake idling patterns. The token checker
// beside the block predicts and compares every token.
// -----------------------------------------------------------------------------
module tb_top;
   import csvt_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 165;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   int         fail_count;
   int         pending_count;

   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         hold_requests = 0;
   int         holds_done = 0;
   logic [7:0] delim = DELIM_RESET;
   logic [7:0] line_bytes[$];

   csvt_req_if req_ch();
   csvt_rsp_if rsp_ch();

   strict_csv_tokenizer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   csv_token_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("*** FAILED ***");
      $finish;
   end

   // Token receiver. A long hold-off, when requested, is counted here while
   // the sender keeps offering bytes.
   initial begin
      int held;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done < hold_requests) begin
            for (held = 0; held < HOLD_CYCLES; held++) begin
               rsp_ch.ready <= 1'b0;
               @(posedge clock);
            end
            holds_done++;
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic logic [7:0] text_byte(input bit in_quotes);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == QUOTE_CHAR || b == NUL_CHAR || b == LF_CHAR || b == CR_CHAR ||
                 (!in_quotes && b == delim));
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] c);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.char_in <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Builds one line in line_bytes. Bytes after a parse error are skipped by
   // the block, so they are left out of the useful count.
   task automatic build_line(input int nfields, output int useful);
      int f;
      int kind;
      int len;
      int k;
      status_type fault;
      line_bytes.delete();
      useful = -1;
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
         line_bytes.push_back(LF_CHAR);
         useful = line_bytes.size();
         return;
      end
      fault = STATUS_OK;
      if ($urandom_range(0, 99) < 15)
         fault = status_type'($urandom_range(STATUS_QUOTE_PLAIN, STATUS_UNTERMINATED));
      for (f = 0; f < nfields; f++) begin
         if (f > 0) line_bytes.push_back(delim);
         if (fault != STATUS_OK && f == nfields - 1) begin
            if (fault == STATUS_QUOTE_PLAIN) begin
               repeat ($urandom_range(1, 3)) line_bytes.push_back(text_byte(1'b0));
               line_bytes.push_back(QUOTE_CHAR);
            end else begin
               line_bytes.push_back(QUOTE_CHAR);
               repeat ($urandom_range(0, 3)) line_bytes.push_back(text_byte(1'b1));
               if (fault == STATUS_GARBAGE) begin
                  line_bytes.push_back(QUOTE_CHAR);
                  line_bytes.push_back(text_byte(1'b0));
               end
            end
            if (fault != STATUS_UNTERMINATED) begin
               useful = line_bytes.size();
               repeat ($urandom_range(0, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end else begin
            // Very long lines use mostly empty fields to reach the count limit.
            kind = (nfields > 6 && $urandom_range(0, 9) != 0) ? 0 : $urandom_range(0, 2);
            if (kind == 1) begin
               repeat ($urandom_range(1, 5)) line_bytes.push_back(text_byte(1'b0));
            end else if (kind == 2) begin
               line_bytes.push_back(QUOTE_CHAR);
               len = $urandom_range(0, 6);
               for (k = 0; k < len; k++) begin
                  case ($urandom_range(0, 7))
                     0: begin
                        line_bytes.push_back(QUOTE_CHAR);
                        line_bytes.push_back(QUOTE_CHAR);
                     end
                     1: line_bytes.push_back(delim);
                     default: line_bytes.push_back(text_byte(1'b1));
                  endcase
               end
               line_bytes.push_back(QUOTE_CHAR);
            end
         end
      end
      if (fault != STATUS_UNTERMINATED || $urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 3))
            0: line_bytes.push_back(LF_CHAR);
            1: line_bytes.push_back(CR_CHAR);
            2: line_bytes.push_back(NUL_CHAR);
            default: begin
               line_bytes.push_back(CR_CHAR);
               line_bytes.push_back(LF_CHAR);
            end
         endcase
      end else begin
         line_bytes.push_back(LF_CHAR);
      end
      if (useful < 0) useful = line_bytes.size();
   endtask

   // The delimiter only changes while the tokenizer is idle. A trailing quote
   // leaves no token behind, hence the settle time after the last one.
   task automatic write_delimiter(input logic [7:0] d);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      delim = d;
   endtask

   task automatic run_phase(input logic [7:0] d, input idle_mode_type mode,
                            input bit hold, input bit long_line);
      int sent;
      int useful;
      write_delimiter(d);
      send_idle_pct = (mode == IDLE_SENDER) ? 51 : (mode == IDLE_BOTH) ? 7 : 0;
      stall_pct = (mode == IDLE_RECEIVER) ? 51 : (mode == IDLE_BOTH) ? 7 : 0;
      if (hold) hold_requests++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         build_line((long_line && sent == 0) ? 300 : $urandom_range(1, 6), useful);
         foreach (line_bytes[i]) send_byte(line_bytes[i]);
         sent += useful;
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      req_ch.valid = 1'b0;
      req_ch.char_in = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty line; plain, quoted and doubled-quote fields with an empty last
      // field; byte extremes; quote in a plain field with a skipped rest of
      // line; garbage after a closing quote; a line ending inside quotes.
      directed = '{LF_CHAR,
                   "a", ",", QUOTE_CHAR, "b", QUOTE_CHAR, QUOTE_CHAR, QUOTE_CHAR, ",",
                   CR_CHAR,
                   8'hFF, 8'h01, NUL_CHAR,
                   "a", QUOTE_CHAR, "x", LF_CHAR,
                   QUOTE_CHAR, "a", QUOTE_CHAR, "b", LF_CHAR,
                   QUOTE_CHAR, "a", LF_CHAR};
      foreach (directed[i]) send_byte(directed[i]);

      run_phase(DELIM_RESET, IDLE_NONE, 1'b0, 1'b0);
      run_phase(DELIM_RESET, IDLE_SENDER, 1'b0, 1'b0);
      run_phase(8'h09, IDLE_RECEIVER, 1'b0, 1'b0);
      run_phase(8'h3B, IDLE_BOTH, 1'b1, 1'b0);
      run_phase(NUL_CHAR, IDLE_NONE, 1'b0, 1'b0);
      run_phase(8'hFF, IDLE_SENDER, 1'b0, 1'b1);
      run_phase(QUOTE_CHAR, IDLE_RECEIVER, 1'b0, 1'b0);
      run_phase(LF_CHAR, IDLE_BOTH, 1'b1, 1'b0);
      run_phase(8'h7F, IDLE_NONE, 1'b0, 1'b0);
      run_phase(DELIM_RESET, IDLE_BOTH, 1'b0, 1'b0);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
